// ----- rtl/core/ddd_pkg.sv -----
// shared types, constants and calendar tables for the date difference core
package ddd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned CountW  = 22;
  localparam int unsigned DayNumW = 23;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // x / 100 as (x * 5243) >> 19, exact for x below 2**15
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              include_end_day;
  } ddd_in_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              date_invalid;
  } ddd_out_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } ddd_date_t;

  // per-stage load strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } ddd_ld_t;

  function automatic logic [7:0] div100(input logic [YearW:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(Div100Mul);
    return p[Div100Shift+7:Div100Shift];
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                   r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ddd_pipe_ctrl.sv -----
// valid bits and per-stage load strobes of the four-stage pipeline
module ddd_pipe_ctrl import ddd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output ddd_ld_t ld_o,
  output logic    out_valid_o,
  input  logic    out_ready_i
);

  logic v1_q, v2_q, v3_q, v4_q;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld_o.s4 = !v4_q || out_ready_i;
    ld_o.s3 = !v3_q || ld_o.s4;
    ld_o.s2 = !v2_q || ld_o.s3;
    ld_o.s1 = !v1_q || ld_o.s2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld_o.s1) v1_q <= in_valid_i;
      if (ld_o.s2) v2_q <= v1_q;
      if (ld_o.s3) v3_q <= v2_q;
      if (ld_o.s4) v4_q <= v3_q;
    end
  end

  assign in_ready_o  = ld_o.s1;
  assign out_valid_o = v4_q;

endmodule

// ----- rtl/core/ddd_day_num.sv -----
// three-stage day number and date check for one calendar date
module ddd_day_num import ddd_pkg::*; (
  input  logic               clk_i,
  input  ddd_ld_t            ld_i,
  input  ddd_date_t          date_i,
  output logic [DayNumW-1:0] day_num_o,
  output logic               ok_o
);

  // stage 1: year products and quotients
  logic [YearW-1:0]   y1_q;
  logic [MonthW-1:0]  m1_q;
  logic [DayW-1:0]    d1_q;
  logic [DayNumW-1:0] mul365_d, mul365_q;
  logic [12:0]        q4_d, q4_q;
  logic [7:0]         qa_d, qa_q;
  logic [5:0]         q400_d, q400_q;
  logic [7:0]         q100_d, q100_q;
  logic [YearW:0]     y_ext, y_p3, y_p99, y_p399;

  always_comb begin
    y_ext    = {1'b0, date_i.year};
    y_p3     = y_ext + 15'd3;
    y_p99    = y_ext + 15'd99;
    y_p399   = y_ext + 15'd399;
    mul365_d = DayNumW'(date_i.year) * DayNumW'(365);
    q4_d     = y_p3[YearW:2];
    qa_d     = div100(y_p99);
    // (y + 399) / 400 as ((y + 399) / 4) / 100
    q400_d   = 6'(div100({2'b00, y_p399[YearW:2]}));
    q100_d   = div100(y_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      y1_q     <= date_i.year;
      m1_q     <= date_i.month;
      d1_q     <= date_i.day;
      mul365_q <= mul365_d;
      q4_q     <= q4_d;
      qa_q     <= qa_d;
      q400_q   <= q400_d;
      q100_q   <= q100_d;
    end
  end

  // stage 2: leap year and day count of the whole years
  logic [MonthW-1:0]  m2_q;
  logic [DayW-1:0]    d2_q;
  logic               leap_d, leap_q;
  logic [DayNumW-1:0] base_d, base_q;
  logic [YearW-1:0]   r100;

  always_comb begin
    r100   = y1_q - YearW'(YearW'(q100_q) * YearW'(100));
    leap_d = (r100 == '0) ? (q100_q[1:0] == 2'd0) : (y1_q[1:0] == 2'd0);
    base_d = mul365_q + DayNumW'(q4_q) - DayNumW'(qa_q) + DayNumW'(q400_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      m2_q   <= m1_q;
      d2_q   <= d1_q;
      leap_q <= leap_d;
      base_q <= base_d;
    end
  end

  // stage 3: month offset, day and range check
  logic [DayNumW-1:0] dn_d, dn_q;
  logic               ok_d, ok_q;

  always_comb begin
    ok_d = (m2_q >= MonthJan) && (m2_q <= MonthDec) && (d2_q != '0) &&
           (d2_q <= month_len(m2_q, leap_q));
    dn_d = base_q + DayNumW'(days_before_month(m2_q)) +
           DayNumW'((m2_q > MonthFeb) && leap_q) + DayNumW'(d2_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      dn_q <= dn_d;
      ok_q <= ok_d;
    end
  end

  assign day_num_o = dn_q;
  assign ok_o      = ok_q;

endmodule

// ----- rtl/core/date_difference_in_days_core.sv -----
// top level of the gregorian date difference core
//
// usage:
//   input channel in_valid_i / in_ready_o carries one item of two dates
//   (start, end) and an include-end-day flag; output channel out_valid_o /
//   out_ready_i returns one item per input item: the day count from start
//   to end (plus one when the flag is set, 0 or the flag alone when start
//   is not before end) and an invalid flag for impossible dates, which
//   forces the count to 0. counts beyond 22 bits saturate.
//   throughput: one item per cycle while out_ready_i is not held low;
//   four register stages, each with its own valid bit, the first three
//   computing both day numbers side by side and the last one doing the
//   subtract and saturate.
//   a stalled receiver holds the output item steady; upstream stages keep
//   filling empty slots, and in_ready_o falls only when all four are full.
//   reset clears every valid bit; the pipeline comes up empty and ready.
module date_difference_in_days_core import ddd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ddd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ddd_out_t out_data_o
);

  ddd_ld_t            ld;
  ddd_date_t          start_date, end_date;
  logic [DayNumW-1:0] start_num, end_num;
  logic               start_ok, end_ok;
  logic               inc1_q, inc2_q, inc3_q;

  ddd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ld_o        (ld),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  always_comb begin
    start_date.year  = in_data_i.start_year;
    start_date.month = in_data_i.start_month;
    start_date.day   = in_data_i.start_day;
    end_date.year    = in_data_i.end_year;
    end_date.month   = in_data_i.end_month;
    end_date.day     = in_data_i.end_day;
  end

  ddd_day_num u_start (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .date_i    (start_date),
    .day_num_o (start_num),
    .ok_o      (start_ok)
  );

  ddd_day_num u_end (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .date_i    (end_date),
    .day_num_o (end_num),
    .ok_o      (end_ok)
  );

  always_ff @(posedge clk_i) begin
    if (ld.s1) inc1_q <= in_data_i.include_end_day;
    if (ld.s2) inc2_q <= inc1_q;
    if (ld.s3) inc3_q <= inc2_q;
  end

  // stage 4: difference, flag and saturation
  logic [DayNumW-1:0] diff;
  logic [DayNumW:0]   sum;
  ddd_out_t           out_d, out_q;

  always_comb begin
    diff = (start_num < end_num) ? (end_num - start_num) : '0;
    sum  = {1'b0, diff} + (DayNumW+1)'(inc3_q);
    out_d.date_invalid = !start_ok || !end_ok;
    if (out_d.date_invalid) begin
      out_d.day_count = '0;
    end else if (sum > (DayNumW+1)'(CountMax)) begin
      out_d.day_count = CountMax;
    end else begin
      out_d.day_count = sum[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld.s4) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/ddd_checker.sv -----
// port-level checks of the date difference core, bound to the top level
module ddd_checker import ddd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input ddd_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input ddd_out_t out_data_o
);

  // a stalled output item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // an impossible date never carries a count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.date_invalid |-> out_data_o.day_count == '0)
    else $error("invalid item with nonzero count");

  // input back-pressure only comes from a stalled output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  // a waiting input item stays offered and unchanged until accepted
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed while stalled");

endmodule

bind date_difference_in_days_core ddd_checker u_ddd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb_date_difference_in_days_core.sv -----
// self-checking testbench for the gregorian date difference core
module tb_date_difference_in_days_core;
  import ddd_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned InW         = $bits(ddd_in_t);

  // expected day counts in arrival order, with the calendar arithmetic that predicts them
  class day_count_board;
    ddd_out_t    expected_counts[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned n;
      case (m)
        2:          n = is_leap(y) ? 29 : 28;
        4, 6, 9, 11: n = 30;
        default:    n = 31;
      endcase
      return n;
    endfunction

    static function int unsigned days_ahead_of(int unsigned m);
      int unsigned n;
      case (m)
        1:       n = 0;
        2:       n = 31;
        3:       n = 59;
        4:       n = 90;
        5:       n = 120;
        6:       n = 151;
        7:       n = 181;
        8:       n = 212;
        9:       n = 243;
        10:      n = 273;
        11:      n = 304;
        default: n = 334;
      endcase
      return n;
    endfunction

    static function bit date_ok(logic [YearW-1:0] y, logic [MonthW-1:0] m,
                                logic [DayW-1:0] d);
      if (m < MonthJan || m > MonthDec) begin
        return 1'b0;
      end
      return (d >= 1) && (d <= month_days(y, m));
    endfunction

    // serial day number, 0000-01-01 is 1
    static function int unsigned day_serial(int unsigned y, int unsigned m, int unsigned d);
      int unsigned n;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      n += days_ahead_of(m);
      if (m > MonthFeb && is_leap(y)) begin
        n += 1;
      end
      return n + d;
    endfunction

    static function ddd_out_t predict_count(ddd_in_t it);
      ddd_out_t    r;
      int unsigned a;
      int unsigned b;
      int unsigned cnt;
      r.day_count    = '0;
      r.date_invalid = 1'b1;
      if (!date_ok(it.start_year, it.start_month, it.start_day) ||
          !date_ok(it.end_year, it.end_month, it.end_day)) begin
        return r;
      end
      a   = day_serial(it.start_year, it.start_month, it.start_day);
      b   = day_serial(it.end_year, it.end_month, it.end_day);
      cnt = (a < b) ? (b - a) : 0;
      cnt += it.include_end_day;
      if (cnt > CountMax) begin
        cnt = CountMax;
      end
      r.day_count    = cnt[CountW-1:0];
      r.date_invalid = 1'b0;
      return r;
    endfunction

    function void note_input(ddd_in_t it);
      expected_counts.push_back(predict_count(it));
    endfunction

    function void check_result(ddd_out_t got);
      ddd_out_t want;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: day_count %0d date_invalid %0d",
                   got.day_count, got.date_invalid);
        end
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: day_count exp %0d got %0d, date_invalid exp %0d got %0d",
                   want.day_count, got.day_count, want.date_invalid, got.date_invalid);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ddd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ddd_out_t out_data_o;

  day_count_board board = new();
  int unsigned    results_seen = 0;
  bit             all_sent = 1'b0;

  date_difference_in_days_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic ddd_in_t make_item(int unsigned sy, int unsigned sm, int unsigned sd,
                                        int unsigned ey, int unsigned em, int unsigned ed,
                                        bit inc);
    ddd_in_t it;
    it.start_year      = sy[YearW-1:0];
    it.start_month     = sm[MonthW-1:0];
    it.start_day       = sd[DayW-1:0];
    it.end_year        = ey[YearW-1:0];
    it.end_month       = em[MonthW-1:0];
    it.end_day         = ed[DayW-1:0];
    it.include_end_day = inc;
    return it;
  endfunction

  function automatic ddd_date_t random_date();
    ddd_date_t   dt;
    int unsigned y;
    int unsigned m;
    // mostly nominal years, now and then the full 14-bit range
    y        = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
    m        = $urandom_range(1, 12);
    dt.year  = y[YearW-1:0];
    dt.month = m[MonthW-1:0];
    dt.day   = DayW'($urandom_range(1, day_count_board::month_days(y, m)));
    return dt;
  endfunction

  function automatic ddd_in_t random_item();
    ddd_date_t   s;
    ddd_date_t   e;
    ddd_date_t   t;
    ddd_in_t     it;
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode >= 90) begin
      it = ddd_in_t'(InW'({$urandom, $urandom}));
      return it;
    end
    s = random_date();
    e = random_date();
    if ($urandom_range(0, 4) == 0) begin
      // nearby dates in the same year, equal ones included
      e.year  = s.year;
      e.month = MonthW'($urandom_range(1, 12));
      e.day   = DayW'($urandom_range(1, day_count_board::month_days(e.year, e.month)));
    end
    if ($urandom_range(0, 9) < 7 && {s.year, s.month, s.day} > {e.year, e.month, e.day}) begin
      t = s;
      s = e;
      e = t;
    end
    if (mode >= 75) begin
      // spoil one field of one date
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 1) == 0) s.month = MonthW'($urandom_range(0, 15));
        else e.month = MonthW'($urandom_range(0, 15));
      end else begin
        if ($urandom_range(0, 1) == 0) s.day = DayW'($urandom_range(0, 31));
        else e.day = DayW'($urandom_range(0, 31));
      end
    end
    return make_item(s.year, s.month, s.day, e.year, e.month, e.day, $urandom_range(0, 1));
  endfunction

  task automatic drive_item(ddd_in_t it, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(it);
  endtask

  // result side: compare every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(out_data_o);
      results_seen++;
    end
  end

  // receiver back-pressure, with one long hold-off to fill the pipeline
  initial begin
    bit          held;
    int unsigned gap;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (!all_sent || board.pending() != 0) begin
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
    out_ready_i <= 1'b1;
  end

  // watchdog on cycles where neither channel moves an item
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    ddd_in_t directed[$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed.push_back(make_item(1, 1, 1, 9999, 12, 31, 1'b0));
    directed.push_back(make_item(1, 1, 1, 9999, 12, 31, 1'b1));
    directed.push_back(make_item(2023, 6, 15, 2023, 6, 15, 1'b0));
    directed.push_back(make_item(2023, 6, 15, 2023, 6, 15, 1'b1));
    directed.push_back(make_item(2024, 3, 1, 2020, 1, 1, 1'b1));
    directed.push_back(make_item(2024, 3, 1, 2020, 1, 1, 1'b0));
    // leap by the 400 rule, not by the 100 rule, plain leap year
    directed.push_back(make_item(2000, 2, 29, 2000, 3, 1, 1'b0));
    directed.push_back(make_item(1900, 2, 29, 1900, 3, 1, 1'b0));
    directed.push_back(make_item(1900, 2, 28, 1900, 3, 1, 1'b1));
    directed.push_back(make_item(2024, 2, 29, 2025, 2, 28, 1'b0));
    directed.push_back(make_item(2023, 2, 29, 2024, 1, 1, 1'b0));
    // impossible months and days, with one valid item among them
    directed.push_back(make_item(2020, 0, 10, 2021, 1, 1, 1'b1));
    directed.push_back(make_item(2020, 1, 10, 2021, 13, 1, 1'b1));
    directed.push_back(make_item(2020, 15, 10, 2021, 1, 1, 1'b0));
    directed.push_back(make_item(2020, 5, 0, 2021, 1, 1, 1'b1));
    directed.push_back(make_item(2020, 4, 31, 2021, 1, 1, 1'b0));
    directed.push_back(make_item(2020, 1, 31, 2020, 12, 31, 1'b0));
    directed.push_back(make_item(2020, 2, 30, 2021, 1, 1, 1'b0));
    // year zero and years beyond the nominal range, saturating count
    directed.push_back(make_item(0, 2, 29, 1, 1, 1, 1'b0));
    directed.push_back(make_item(0, 1, 1, 16383, 12, 31, 1'b1));
    directed.push_back(make_item(9999, 12, 31, 16383, 12, 31, 1'b0));
    directed.push_back(make_item(16383, 15, 31, 16383, 15, 31, 1'b1));
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 1'b0));

    foreach (directed[i]) begin
      drive_item(directed[i], 1'b0);
    end
    for (int unsigned n = 0; n < RandomItems; n++) begin
      // a stretch with no sender idling
      drive_item(random_item(), n >= 500 && n < 650);
    end
    in_valid_i <= 1'b0;
    all_sent = 1'b1;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
